/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// All macros sample on clock and are disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop holds in every cycle
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// cond implies prop in the same cycle
`define ASSERT_IMPLIES(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// cond implies prop in the next cycle
`define ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/kmp_pkg.sv */
// ---------------------------------------------------------------------------
// kmp_pkg
// Constants and types shared by the string matcher, its cells and channels.
// ---------------------------------------------------------------------------
package kmp_pkg;

   localparam int MAX_PATTERN  = 256;
   localparam int POS_BITS     = 16;

   localparam int GROUP_CELLS  = 16;
   localparam int N_GROUPS     = (MAX_PATTERN + GROUP_CELLS - 1) / GROUP_CELLS;
   localparam int N_CELLS      = N_GROUPS * GROUP_CELLS;
   localparam int CNT_BITS     = $clog2(N_CELLS + 1);
   localparam int LEN_BITS     = $clog2(MAX_PATTERN + 1);
   localparam int OFF_BITS     = $clog2(GROUP_CELLS);
   localparam int GRP_BITS     = (N_GROUPS > 1) ? $clog2(N_GROUPS) : 1;

   localparam int BYTE_BITS    = 8;
   localparam int MLEN_BITS    = 9;
   localparam int START_BITS   = 16;
   localparam int STATUS_BITS  = 2;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   localparam logic REQ_PATTERN = 1'b0;
   localparam logic REQ_TEXT    = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK         = 2'd0,
      STAT_DROPPED    = 2'd1,
      STAT_NO_PATTERN = 2'd2,
      STAT_SATURATED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK
   } state_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                 load_en;
      logic                 text_en;
      logic                 restart;
      logic [BYTE_BITS-1:0] data;
      logic [CNT_BITS-1:0]  length;
   } cell_ctrl_type;

   // registered summary of one group of cells
   typedef struct packed {
      logic                any_cand;
      logic                any_hit;
      logic [OFF_BITS-1:0] top_off;
   } group_sum_type;

endpackage

/* rtl/kmp_if.sv */
// ---------------------------------------------------------------------------
// kmp channel interfaces
// Valid/ready channels for request and response transactions.
// ---------------------------------------------------------------------------
interface kmp_req_if;
   import kmp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [BYTE_BITS-1:0] byte_value;
   logic                 item_first;

   modport source (output valid, output req_type, output byte_value, output item_first,
                   input ready);
   modport sink   (input valid, input req_type, input byte_value, input item_first,
                   output ready);
endinterface

interface kmp_rsp_if;
   import kmp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   match_found;
   logic [START_BITS-1:0]  match_start;
   logic [MLEN_BITS-1:0]   matched_length;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output match_found, output match_start,
                   output matched_length, output status, input ready);
   modport sink   (input valid, input match_found, input match_start,
                   input matched_length, input status, output ready);
endinterface

/* rtl/kmp_cell.sv */
// ---------------------------------------------------------------------------
// kmp_cell
// One pattern position: holds its byte and a flag saying that the pattern
// prefix ending here matches the text seen so far.
// ---------------------------------------------------------------------------
module kmp_cell import kmp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [CNT_BITS-1:0] cell_index,
   input  logic                left_flag,
   output logic                flag,
   output logic                cand,
   output logic                hit
);

   logic [BYTE_BITS-1:0] pat_ff, pat_in;
   logic                 flag_ff, flag_in;
   logic                 active, last, chain_in;

   assign active = cell_index < ctrl.length;
   assign last   = (cell_index + CNT_BITS'(1)) == ctrl.length;

   // first cell always starts a prefix; others extend the neighbour's
   assign chain_in = (cell_index == '0) ? 1'b1 : (left_flag & ~ctrl.restart);

   always_comb begin
      pat_in  = pat_ff;
      flag_in = flag_ff;
      if (ctrl.load_en) begin
         flag_in = 1'b0;
         if (cell_index == ctrl.length) begin
            pat_in = ctrl.data;
         end
      end else if (ctrl.text_en) begin
         flag_in = chain_in & active & (pat_ff == ctrl.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   assign flag = flag_ff;
   assign cand = flag_ff & ~last;
   assign hit  = flag_ff & last;

endmodule

/* rtl/kmp_group_scan.sv */
// ---------------------------------------------------------------------------
// kmp_group_scan
// Registered leading-flag search over one group of cells.
// ---------------------------------------------------------------------------
module kmp_group_scan import kmp_pkg::*; (
   input  logic                   clock,
   input  logic                   load,
   input  logic [GROUP_CELLS-1:0] cand,
   input  logic [GROUP_CELLS-1:0] hit,
   output group_sum_type          sum
);

   group_sum_type sum_ff, sum_in;

   always_comb begin
      sum_in.any_cand = |cand;
      sum_in.any_hit  = |hit;
      sum_in.top_off  = '0;
      for (int i = 0; i < GROUP_CELLS; i++) begin
         if (cand[i]) begin
            sum_in.top_off = OFF_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

/* rtl/kmp_string_matcher.sv */
// ---------------------------------------------------------------------------
// kmp_string_matcher
// Streaming pattern matcher: pattern bytes load, text bytes are searched.
// ---------------------------------------------------------------------------
// Each request transaction gives exactly one response transaction. A pattern
// byte (req_type 0) is written into a row of MAX_PATTERN cells, one byte per
// cell; item_first restarts the pattern. A text byte (req_type 1) is compared
// in every cell at once and each cell keeps a flag meaning "the pattern prefix
// ending here is a suffix of the text"; the flags ripple one cell per text
// byte, so no failure table is needed. The longest flagged prefix shorter than
// the pattern is the KMP matched length; a flag in the last pattern cell is a
// full match, reported with its start index. Each transaction passes the steps
// accept (cells update), group scan (16-cell leading-flag search, registered)
// and pick (search across groups into the response register). The search over
// the cell row is done in two levels. A new request is taken while an earlier
// response still waits; the pick step holds until the
// response register is free. Stores power up undefined and need no clearing
// pass, so the block accepts requests straight after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kmp_string_matcher import kmp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   kmp_req_if.sink    req_if,
   kmp_rsp_if.source  rsp_if
);

   // control
   state_type state_ff, state_in;
   logic      req_fire, is_load, is_text;
   logic      scan_load, pick_load;

   // architectural state
   logic [LEN_BITS-1:0] pat_len_ff, pat_len_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;

   // per-transaction data carried to the pick step
   logic                  item_text_ff;
   status_type            item_status_ff, item_status_in;
   logic [START_BITS-1:0] item_start_ff, item_start_in;
   logic [LEN_BITS-1:0]   item_len_ff;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [START_BITS-1:0] rsp_start_ff;
   logic [MLEN_BITS-1:0]  rsp_len_ff;
   status_type            rsp_status_ff;
   logic                  rsp_text_ff;

   // accept-side datapath
   logic [LEN_BITS-1:0] write_idx;
   logic                pat_full;
   logic [POS_BITS-1:0] text_idx;
   logic [POS_BITS-1:0] start_pos;

   // cell row
   cell_ctrl_type       cell_ctrl;
   logic [N_CELLS-1:0]  flag_vec, left_vec, cand_vec, hit_vec;
   group_sum_type       grp_sum [N_GROUPS];

   // pick-side search
   logic                any_cand, found;
   logic [GRP_BITS-1:0] best_grp;
   logic [OFF_BITS-1:0] best_off;
   logic [CNT_BITS-1:0] progress;

   // ---------------------------------------------------------------------
   // Sequencer: accept -> scan -> pick
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_SCAN;
         ST_SCAN: state_in = ST_PICK;
         ST_PICK: if (!rsp_valid_ff || rsp_if.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      scan_load    = 1'b0;
      pick_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_if.ready = 1'b1;
         ST_SCAN: scan_load    = 1'b1;
         ST_PICK: pick_load    = !rsp_valid_ff || rsp_if.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_fire = req_if.valid & req_if.ready;
   assign is_load  = req_fire & (req_if.req_type == REQ_PATTERN);
   assign is_text  = req_fire & (req_if.req_type == REQ_TEXT);

   // ---------------------------------------------------------------------
   // Pattern length and text position
   // ---------------------------------------------------------------------
   // item_first on a pattern byte restarts the pattern at index zero
   assign write_idx = req_if.item_first ? '0 : pat_len_ff;
   assign pat_full  = write_idx == LEN_BITS'(MAX_PATTERN);

   // item_first on a text byte restarts the position count
   assign text_idx  = req_if.item_first ? '0 : pos_ff;
   // where a match ending at this byte would begin, modulo the counter width
   assign start_pos = text_idx - POS_BITS'(pat_len_ff) + POS_BITS'(1);

   always_comb begin
      pat_len_in     = pat_len_ff;
      pos_in         = pos_ff;
      item_status_in = STAT_OK;
      item_start_in  = START_BITS'(start_pos);
      if (is_load) begin
         if (pat_full) begin
            item_status_in = STAT_DROPPED;
         end else begin
            pat_len_in = write_idx + LEN_BITS'(1);
         end
      end else if (is_text) begin
         // position saturates at its top value
         pos_in = (text_idx == POS_MAX) ? text_idx : text_idx + POS_BITS'(1);
         if (pat_len_ff == '0) begin
            item_status_in = STAT_NO_PATTERN;
         end else if (text_idx == POS_MAX) begin
            item_status_in = STAT_SATURATED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= '0;
         pos_ff     <= '0;
      end else begin
         pat_len_ff <= pat_len_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_text_ff   <= is_text;
         item_status_ff <= item_status_in;
         item_start_ff  <= item_start_in;
         item_len_ff    <= pat_len_in;
      end
   end

   // ---------------------------------------------------------------------
   // Cell row. During a load the length lane carries the write index;
   // otherwise it carries the pattern length so cells know their range.
   // ---------------------------------------------------------------------
   always_comb begin
      cell_ctrl.load_en = is_load;
      cell_ctrl.text_en = is_text;
      cell_ctrl.restart = req_if.item_first;
      cell_ctrl.data    = req_if.byte_value;
      cell_ctrl.length  = is_load ? CNT_BITS'(write_idx) : CNT_BITS'(pat_len_ff);
   end

   // each cell extends the prefix flag of its left neighbour
   assign left_vec = {flag_vec[N_CELLS-2:0], 1'b0};

   for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
      kmp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .cell_index (CNT_BITS'(c)),
         .left_flag  (left_vec[c]),
         .flag       (flag_vec[c]),
         .cand       (cand_vec[c]),
         .hit        (hit_vec[c])
      );
   end

   for (genvar g = 0; g < N_GROUPS; g++) begin : g_group
      kmp_group_scan u_group (
         .clock (clock),
         .load  (scan_load),
         .cand  (cand_vec[g*GROUP_CELLS +: GROUP_CELLS]),
         .hit   (hit_vec[g*GROUP_CELLS +: GROUP_CELLS]),
         .sum   (grp_sum[g])
      );
   end

   // ---------------------------------------------------------------------
   // Pick: highest group holding a proper-prefix flag, plus any full match
   // ---------------------------------------------------------------------
   always_comb begin
      any_cand = 1'b0;
      found    = 1'b0;
      best_grp = '0;
      best_off = '0;
      for (int g = 0; g < N_GROUPS; g++) begin
         found = found | grp_sum[g].any_hit;
         if (grp_sum[g].any_cand) begin
            any_cand = 1'b1;
            best_grp = GRP_BITS'(g);
            best_off = grp_sum[g].top_off;
         end
      end
      progress = any_cand ? CNT_BITS'({best_grp, best_off}) + CNT_BITS'(1) : '0;
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pick_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pick_load) begin
         rsp_text_ff   <= item_text_ff;
         rsp_status_ff <= item_status_ff;
         if (item_text_ff) begin
            rsp_found_ff <= found;
            rsp_start_ff <= found ? item_start_ff : '0;
            rsp_len_ff   <= MLEN_BITS'(progress);
         end else begin
            rsp_found_ff <= 1'b0;
            rsp_start_ff <= '0;
            rsp_len_ff   <= MLEN_BITS'(item_len_ff);
         end
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.match_found    = rsp_found_ff;
   assign rsp_if.match_start    = rsp_start_ff;
   assign rsp_if.matched_length = rsp_len_ff;
   assign rsp_if.status         = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_ALWAYS(a_single_hit, $onehot0(hit_vec), "more than one cell reports a full match")
   `ASSERT_NEXT(a_accept_scan, req_fire, state_ff == ST_SCAN, "accept not followed by scan")
   `ASSERT_NEXT(a_load_clears, is_load, flag_vec == '0, "pattern load left prefix flags set")
   `ASSERT_IMPLIES(a_found_text, rsp_valid_ff && rsp_found_ff,
      rsp_text_ff && (rsp_status_ff != STAT_NO_PATTERN), "match reported without pattern text")

endmodule

/* tb/sv/kmp_string_matcher_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kmp_string_matcher_test
// Self-checking bench for the streaming KMP matcher. A scoreboard class keeps
// its own copy of the pattern, border table and text position. It predicts
// one response per accepted request transaction and checks every response
// against the oldest prediction, field by field. Stimulus runs in several
// parts: a directed opening, a full-length pattern with overflow, and random
// pattern and text sequences. Both channels idle at random.
// ---------------------------------------------------------------------------
module kmp_string_matcher_test;
   import kmp_pkg::*;

   localparam int CYCLE_LIMIT  = 200_000;    // slowest legal run is well under a third
   localparam int RANDOM_ITEMS = 1300;
   localparam int TAIL_CYCLES  = 16;         // pipeline is three deep, so this is ample
   localparam int MAX_REPORTS  = 100;        // keep a broken run's log readable

   typedef struct packed {
      logic                  match_found;
      logic [START_BITS-1:0] match_start;
      logic [MLEN_BITS-1:0]  matched_length;
      status_type            status;
   } match_result_type;

   // -----------------------------------------------------------------------
   // Scoreboard: shadow of the matcher state plus the queue of predicted
   // responses, oldest first.
   // -----------------------------------------------------------------------
   class kmp_scoreboard;
      logic [BYTE_BITS-1:0] pat_bytes [MAX_PATTERN];
      logic [LEN_BITS-1:0]  border_of [MAX_PATTERN];
      logic [LEN_BITS-1:0]  pat_len;
      logic [LEN_BITS-1:0]  border_len;    // running border while loading
      logic [LEN_BITS-1:0]  progress;      // matched prefix length in the text
      logic [POS_BITS-1:0]  text_pos;
      match_result_type     awaited_results [$];
      int unsigned          errors, checked;
      int unsigned          n_matches, n_dropped, n_no_pattern, n_saturated;

      function new();
         pat_len = '0;
         border_len = '0;
         progress = '0;
         text_pos = '0;
      endfunction

      // One step of the matcher for an accepted request transaction.
      function match_result_type predict_match(logic kind, logic [BYTE_BITS-1:0] value,
                                               logic first);
         match_result_type     r;
         logic [LEN_BITS-1:0]  k;
         logic [LEN_BITS-1:0]  idx;
         logic [POS_BITS-1:0]  pos;
         r = '0;
         r.status = STAT_OK;
         if (kind == REQ_PATTERN) begin
            if (first) begin
               pat_len = '0;
               border_len = '0;
            end
            progress = '0;   // pattern changed, text progress is void
            if (pat_len == MAX_PATTERN) begin
               r.status = STAT_DROPPED;
            end else begin
               idx = pat_len;
               pat_bytes[idx] = value;
               if (idx == 0) begin
                  border_len = '0;
                  border_of[0] = '0;
               end else begin
                  k = border_len;
                  if (k >= idx) k = '0;
                  while (k > 0 && pat_bytes[k] != value) k = border_of[k - 1];
                  if (pat_bytes[k] == value) k = k + 1'b1;
                  border_of[idx] = k;
                  border_len = k;
               end
               pat_len = idx + 1'b1;
            end
            r.matched_length = MLEN_BITS'(pat_len);
         end else begin
            if (first) begin
               progress = '0;
               text_pos = '0;
            end
            pos = text_pos;
            if (pos == POS_MAX) r.status = STAT_SATURATED;
            if (text_pos != POS_MAX) text_pos = text_pos + 1'b1;
            if (pat_len == 0) begin
               progress = '0;
               r.matched_length = '0;
               r.status = STAT_NO_PATTERN;
            end else begin
               k = progress;
               if (k >= pat_len) k = '0;
               while (k > 0 && pat_bytes[k] != value) k = border_of[k - 1];
               if (pat_bytes[k] == value) k = k + 1'b1;
               if (k == pat_len) begin
                  r.match_found = 1'b1;
                  r.match_start = START_BITS'(pos - (POS_BITS'(pat_len) - 1'b1));
                  k = border_of[pat_len - 1'b1];
               end
               progress = k;
               r.matched_length = MLEN_BITS'(k);
            end
         end
         return r;
      endfunction

      function void note_request(logic kind, logic [BYTE_BITS-1:0] value, logic first);
         match_result_type r;
         r = predict_match(kind, value, first);
         if (r.match_found) n_matches++;
         case (r.status)
            STAT_DROPPED:    n_dropped++;
            STAT_NO_PATTERN: n_no_pattern++;
            STAT_SATURATED:  n_saturated++;
            default: ;
         endcase
         awaited_results.push_back(r);
      endfunction

      function void flag(string what, logic [15:0] want, logic [15:0] got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      endfunction

      function void check_response(match_result_type got);
         match_result_type want;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response with none awaited, expected none, actual %h",
                        $time, got);
            return;
         end
         want = awaited_results.pop_front();
         checked++;
         if (got.match_found !== want.match_found)
            flag("match_found", 16'(want.match_found), 16'(got.match_found));
         if (got.match_start !== want.match_start)
            flag("match_start", want.match_start, got.match_start);
         if (got.matched_length !== want.matched_length)
            flag("matched_length", 16'(want.matched_length), 16'(got.matched_length));
         if (got.status !== want.status)
            flag("status", 16'(want.status), 16'(got.status));
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -----------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;        // set: neither side idles
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;

   kmp_scoreboard sb = new();

   kmp_req_if req_if ();
   kmp_rsp_if rsp_if ();

   kmp_string_matcher dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Request side. Called at a falling edge, returns at a falling edge, so
   // every drive happens half a cycle away from the sampling edge. Valid is
   // either held high into the next transaction or dropped for idle cycles,
   // never both in one step.
   // -----------------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [BYTE_BITS-1:0] value,
                            input logic first);
      while (!steady && $urandom_range(99) < 22) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.byte_value <= value;
      req_if.item_first <= first;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(kind, value, first);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted response has been checked.
   task automatic drain_pause();
      req_if.valid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(negedge clock);
   endtask

   // -----------------------------------------------------------------------
   // Response side: ready chosen at the falling edge, transaction taken at
   // the rising edge.
   // -----------------------------------------------------------------------
   initial begin : response_side
      match_result_type got;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= !reset && (steady || $urandom_range(99) >= 22);
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.match_found    = rsp_if.match_found;
            got.match_start    = rsp_if.match_start;
            got.matched_length = rsp_if.matched_length;
            got.status         = status_type'(rsp_if.status);
            sb.check_response(got);
         end
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------------
   initial begin : stimulus
      logic [BYTE_BITS-1:0] alpha [3];
      logic [BYTE_BITS-1:0] b;
      logic                 first;
      int unsigned          base, seq, roll, plen, tlen, i, j, held;

      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_PATTERN;
      req_if.byte_value = '0;
      req_if.item_first = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed opening ---
      // text before any pattern: no-pattern status, position still moves
      send_item(REQ_TEXT, 8'h00, 1'b1);
      send_item(REQ_TEXT, 8'hFF, 1'b0);
      // pattern 00 FF 00, border table 0 0 1
      send_item(REQ_PATTERN, 8'h00, 1'b1);
      send_item(REQ_PATTERN, 8'hFF, 1'b0);
      send_item(REQ_PATTERN, 8'h00, 1'b0);
      // overlapping occurrences, then a mismatch falling back to zero
      send_item(REQ_TEXT, 8'h00, 1'b1);
      send_item(REQ_TEXT, 8'hFF, 1'b0);
      send_item(REQ_TEXT, 8'h00, 1'b0);
      send_item(REQ_TEXT, 8'hFF, 1'b0);
      send_item(REQ_TEXT, 8'h00, 1'b0);
      send_item(REQ_TEXT, 8'h55, 1'b0);
      send_item(REQ_TEXT, 8'hAA, 1'b0);
      // single-byte pattern 80: a match at each 80 byte, none at 7F
      send_item(REQ_PATTERN, 8'h80, 1'b1);
      send_item(REQ_TEXT, 8'h80, 1'b0);
      send_item(REQ_TEXT, 8'h80, 1'b0);
      send_item(REQ_TEXT, 8'h7F, 1'b0);
      // appending mid-text clears progress but keeps the position
      send_item(REQ_TEXT, 8'h80, 1'b0);
      send_item(REQ_PATTERN, 8'h7F, 1'b0);
      send_item(REQ_TEXT, 8'h80, 1'b0);
      send_item(REQ_TEXT, 8'h7F, 1'b0);
      send_item(REQ_TEXT, 8'h80, 1'b1);
      send_item(REQ_TEXT, 8'h7F, 1'b0);
      drain_pause();

      // --- full-length pattern, overflow bytes dropped ---
      for (i = 0; i < MAX_PATTERN + 2; i++)
         send_item(REQ_PATTERN, (i < MAX_PATTERN) ? 8'h61 : 8'h62, i == 0);
      for (i = 0; i < MAX_PATTERN + 60; i++)
         send_item(REQ_TEXT, (i == MAX_PATTERN + 20) ? 8'h62 : 8'h61, i == 0);
      drain_pause();

      // --- random pattern and text sequences over a small alphabet ---
      for (i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(255));
      base = items_sent;
      seq = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         seq++;
         steady = (items_sent - base >= 700) && (items_sent - base < 1000);
         if (seq % 40 == 0) drain_pause();
         roll = $urandom_range(99);
         if (roll < 10) begin
            // noise: every field at random
            repeat ($urandom_range(1, 10))
               send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
         end else if (roll < 45) begin
            if ($urandom_range(1)) begin
               for (i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(255));
               if ($urandom_range(99) < 40) alpha[2] = alpha[1];
            end
            roll = $urandom_range(99);
            if (roll < 85)      plen = $urandom_range(1, 6);
            else if (roll < 97) plen = $urandom_range(7, 24);
            else                plen = $urandom_range(MAX_PATTERN - 3, MAX_PATTERN + 3);
            first = ($urandom_range(9) != 0);
            for (i = 0; i < plen; i++)
               send_item(REQ_PATTERN, alpha[$urandom_range(2)], first && i == 0);
         end else begin
            tlen = $urandom_range(10, 60);
            first = ($urandom_range(4) != 0);
            i = 0;
            while (i < tlen) begin
               if (sb.pat_len > 0 && $urandom_range(99) < 8) begin
                  // plant a copy of the loaded pattern
                  held = 32'(sb.pat_len);
                  for (j = 0; j < held; j++)
                     send_item(REQ_TEXT, sb.pat_bytes[j], first && i == 0 && j == 0);
                  i += held;
               end else begin
                  b = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : alpha[$urandom_range(2)];
                  send_item(REQ_TEXT, b, first && i == 0);
                  i++;
               end
            end
         end
      end
      steady = 1'b0;

      // --- wind down ---
      drain_pause();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d transactions, %0d responses checked, %0d matches",
               items_sent, sb.checked, sb.n_matches);
      $display("dropped pattern bytes %0d, text without pattern %0d, saturated %0d",
               sb.n_dropped, sb.n_no_pattern, sb.n_saturated);
      if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d errors, %0d responses missing", sb.errors,
                  sb.awaited_results.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
